// ===== sv/bim_pkg.sv =====
// ----------------------------------------------------------------------------
// bim_pkg
// Shared types, constants and the hash function of the bidirectional id map.
// ----------------------------------------------------------------------------
package bim_pkg;

    // Label store: one 32-bit label per dense vertex index
    localparam int LABEL_DEPTH = 1024;
    localparam int LABEL_AW    = $clog2(LABEL_DEPTH);
    localparam int LABEL_W     = 32;

    // Reverse hash: twice as many slots as labels, each holds index+1 or 0
    localparam int SLOT_COUNT  = 2 * LABEL_DEPTH;
    localparam int SLOT_AW     = $clog2(SLOT_COUNT);
    localparam int FILL_W      = LABEL_AW + 1;

    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;
    localparam logic [31:0] MISS_WORD = 32'hFFFF_FFFF;

    // Opcodes
    localparam logic [1:0] OP_INSERT       = 2'd0;
    localparam logic [1:0] OP_LABEL_OF_IDX = 2'd1;
    localparam logic [1:0] OP_IDX_OF_LABEL = 2'd2;

    // Result kinds chosen by the controller
    localparam logic [2:0] RES_MISS   = 3'd0;
    localparam logic [2:0] RES_FULL   = 3'd1;
    localparam logic [2:0] RES_INSERT = 3'd2;
    localparam logic [2:0] RES_FWD    = 3'd3;
    localparam logic [2:0] RES_REV    = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] label;
        logic [9:0]         vertex_index;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] answer;
        logic               hit;
        logic               table_full;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic       accept;
        logic       clear_step;
        logic       label_append;
        logic       hash_rd;
        logic       hash_write;
        logic       entry_rd;
        logic       fwd_rd;
        logic       slot_advance;
        logic       load_result;
        logic [2:0] result_kind;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       full;
        logic       fwd_in_range;
        logic       entry_empty;
        logic       label_match;
        logic       clear_last;
        logic       out_free;
    } status_t;

    // Multiplicative hash modulo the slot count: only the low bits matter
    function automatic logic [SLOT_AW-1:0] home_slot(input logic [31:0] lab);
        logic [2*SLOT_AW-1:0] prod;
        prod = lab[SLOT_AW-1:0] * HASH_MULT[SLOT_AW-1:0];
        return prod[SLOT_AW-1:0];
    endfunction

    // Slot that the preloaded label -1 occupies after reset
    localparam logic [SLOT_AW-1:0] HOME_MISS = home_slot(MISS_WORD);

endpackage

// ===== sv/bim_ram.sv =====
// ----------------------------------------------------------------------------
// bim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bim_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port: hold data when not reading
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bim_ctrl.sv =====
// ----------------------------------------------------------------------------
// bim_ctrl
// Sequencer: clearing pass, decode, hash probing and result hand-off.
// ----------------------------------------------------------------------------
module bim_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bim_pkg::status_t st,
    output bim_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DECODE   = 3'd2;
    localparam logic [2:0] ST_HASH_RD  = 3'd3;
    localparam logic [2:0] ST_HASH_CHK = 3'd4;
    localparam logic [2:0] ST_LBL_CHK  = 3'd5;
    localparam logic [2:0] ST_FWD_CHK  = 3'd6;
    localparam logic [2:0] ST_OUT      = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] kind_reg, kind_next;

    // State and result kind registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            kind_reg  <= bim_pkg::RES_MISS;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.result_kind = kind_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (st.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (st.opcode)
                    bim_pkg::OP_INSERT: begin
                        if (st.full) begin
                            kind_next  = bim_pkg::RES_FULL;
                            state_next = ST_OUT;
                        end else begin
                            cmd.label_append = 1'b1;
                            state_next       = ST_HASH_RD;
                        end
                    end
                    bim_pkg::OP_LABEL_OF_IDX: begin
                        if (st.fwd_in_range) begin
                            cmd.fwd_rd = 1'b1;
                            state_next = ST_FWD_CHK;
                        end else begin
                            kind_next  = bim_pkg::RES_MISS;
                            state_next = ST_OUT;
                        end
                    end
                    bim_pkg::OP_IDX_OF_LABEL: begin
                        state_next = ST_HASH_RD;
                    end
                    default: begin
                        kind_next  = bim_pkg::RES_MISS;
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_HASH_RD: begin
                cmd.hash_rd = 1'b1;
                state_next  = ST_HASH_CHK;
            end
            ST_HASH_CHK: begin
                // Empty slot ends the probe; an insert claims it
                if (st.entry_empty) begin
                    if (st.opcode == bim_pkg::OP_INSERT) begin
                        cmd.hash_write = 1'b1;
                        kind_next      = bim_pkg::RES_INSERT;
                    end else begin
                        kind_next = bim_pkg::RES_MISS;
                    end
                    state_next = ST_OUT;
                end else begin
                    cmd.entry_rd = 1'b1;
                    state_next   = ST_LBL_CHK;
                end
            end
            ST_LBL_CHK: begin
                // Matching label: first index wins, so an insert leaves the slot
                if (st.label_match) begin
                    if (st.opcode == bim_pkg::OP_INSERT) begin
                        kind_next = bim_pkg::RES_INSERT;
                    end else begin
                        kind_next = bim_pkg::RES_REV;
                    end
                    state_next = ST_OUT;
                end else begin
                    cmd.slot_advance = 1'b1;
                    state_next       = ST_HASH_RD;
                end
            end
            ST_FWD_CHK: begin
                kind_next  = bim_pkg::RES_FWD;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (st.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/bim_dpath.sv =====
// ----------------------------------------------------------------------------
// bim_dpath
// Label store, reverse hash memory, operand registers and output register.
// ----------------------------------------------------------------------------
module bim_dpath (
    input  logic                aclk,
    input  logic                aresetn,
    input  bim_pkg::in_word_t   s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output bim_pkg::out_word_t  m_word,
    input  bim_pkg::cmd_t       cmd,
    output bim_pkg::status_t    st
);

    logic [1:0]                    op_reg;
    logic [31:0]                   lab_reg;
    logic [bim_pkg::LABEL_AW-1:0]  vix_reg;
    logic [bim_pkg::SLOT_AW-1:0]   slot_reg;
    logic [bim_pkg::FILL_W-1:0]    entry_reg;
    logic [bim_pkg::FILL_W-1:0]    fill_reg;
    logic [bim_pkg::SLOT_AW-1:0]   clear_cnt_reg;
    logic                          m_valid_reg;
    bim_pkg::out_word_t            out_reg;

    logic                          lbl_we;
    logic [bim_pkg::LABEL_AW-1:0]  lbl_waddr;
    logic [31:0]                   lbl_wdata;
    logic                          lbl_re;
    logic [bim_pkg::LABEL_AW-1:0]  lbl_raddr;
    logic [31:0]                   lbl_rdata;
    logic                          hash_we;
    logic [bim_pkg::SLOT_AW-1:0]   hash_waddr;
    logic [bim_pkg::FILL_W-1:0]    hash_wdata;
    logic [bim_pkg::FILL_W-1:0]    hash_rdata;
    logic [bim_pkg::FILL_W-1:0]    entry_minus1;

    // Latch the incoming word and its home slot
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= s_word.opcode;
            lab_reg <= 32'(s_word.label);
            vix_reg <= s_word.vertex_index;
        end
        if (cmd.accept) begin
            slot_reg <= bim_pkg::home_slot(32'(s_word.label));
        end else if (cmd.slot_advance) begin
            slot_reg <= slot_reg + 1'b1;
        end
        if (cmd.entry_rd) begin
            entry_reg <= hash_rdata;
        end
    end

    // Fill count and clearing counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= bim_pkg::FILL_W'(1);
            clear_cnt_reg <= '0;
        end else begin
            if (cmd.load_result && cmd.result_kind == bim_pkg::RES_INSERT) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.clear_step) begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
        end
    end

    // Label store ports: preload index 0, append on insert
    assign entry_minus1 = hash_rdata - 1'b1;
    assign lbl_we    = (cmd.clear_step && clear_cnt_reg == '0) || cmd.label_append;
    assign lbl_waddr = cmd.clear_step ? '0 : fill_reg[bim_pkg::LABEL_AW-1:0];
    assign lbl_wdata = cmd.clear_step ? bim_pkg::MISS_WORD : lab_reg;
    assign lbl_re    = cmd.fwd_rd || cmd.entry_rd;
    assign lbl_raddr = cmd.fwd_rd ? vix_reg : entry_minus1[bim_pkg::LABEL_AW-1:0];

    // Reverse hash ports: clear all slots, mark -1 at its home, claim on insert
    assign hash_we    = cmd.clear_step || cmd.hash_write;
    assign hash_waddr = cmd.clear_step ? clear_cnt_reg : slot_reg;
    always_comb begin
        if (cmd.clear_step) begin
            hash_wdata = (clear_cnt_reg == bim_pkg::HOME_MISS) ?
                         bim_pkg::FILL_W'(1) : '0;
        end else begin
            hash_wdata = fill_reg + 1'b1;
        end
    end

    bim_ram #(
        .WIDTH (bim_pkg::LABEL_W),
        .DEPTH (bim_pkg::LABEL_DEPTH)
    ) u_label_ram (
        .aclk  (aclk),
        .we    (lbl_we),
        .waddr (lbl_waddr),
        .wdata (lbl_wdata),
        .re    (lbl_re),
        .raddr (lbl_raddr),
        .rdata (lbl_rdata)
    );

    bim_ram #(
        .WIDTH (bim_pkg::FILL_W),
        .DEPTH (bim_pkg::SLOT_COUNT)
    ) u_hash_ram (
        .aclk  (aclk),
        .we    (hash_we),
        .waddr (hash_waddr),
        .wdata (hash_wdata),
        .re    (cmd.hash_rd),
        .raddr (slot_reg),
        .rdata (hash_rdata)
    );

    // Output register: load a result word, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            case (cmd.result_kind)
                bim_pkg::RES_FULL: begin
                    out_reg <= '{answer: bim_pkg::MISS_WORD, hit: 1'b0, table_full: 1'b1};
                end
                bim_pkg::RES_INSERT: begin
                    out_reg <= '{answer: 32'(fill_reg), hit: 1'b1, table_full: 1'b0};
                end
                bim_pkg::RES_FWD: begin
                    out_reg <= '{answer: lbl_rdata, hit: 1'b1, table_full: 1'b0};
                end
                bim_pkg::RES_REV: begin
                    out_reg <= '{answer: 32'(entry_reg - 1'b1), hit: 1'b1,
                                 table_full: 1'b0};
                end
                default: begin
                    out_reg <= '{answer: bim_pkg::MISS_WORD, hit: 1'b0, table_full: 1'b0};
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

    // Status back to the controller
    assign st.opcode       = op_reg;
    assign st.full         = (fill_reg >= bim_pkg::FILL_W'(bim_pkg::LABEL_DEPTH));
    assign st.fwd_in_range = ({1'b0, vix_reg} < fill_reg);
    assign st.entry_empty  = (hash_rdata == '0);
    assign st.label_match  = (lbl_rdata == lab_reg);
    assign st.clear_last   = (clear_cnt_reg == bim_pkg::SLOT_AW'(bim_pkg::SLOT_COUNT - 1));
    assign st.out_free     = !m_valid_reg || m_ready;

endmodule

// ===== sv/bidirectional_id_map_core.sv =====
// In-range forward lookup: decode, then a label store read; forward miss, dropped insert
// and unused opcode go from decode to the result. Insert and reverse lookup probe from
// the home slot, reading the label of each occupied slot, until an empty slot or the
// matching label ends it. The next word is accepted in the cycle after the result loads.
// One word is in flight at a time; a finished result waits in the output register.
// Reset: synchronous, active low; a pass clearing every slot, s_ready low, preloads -1 at 0.
// ----------------------------------------------------------------------------
// bidirectional_id_map_core
// Two-way map between dense vertex indices and 32-bit labels.
// ----------------------------------------------------------------------------
module bidirectional_id_map_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bim_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output bim_pkg::out_word_t m_word
);

    bim_pkg::cmd_t    cmd;
    bim_pkg::status_t st;

    bim_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    bim_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .cmd     (cmd),
        .st      (st)
    );

    // One word in flight: no accept in the cycle after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a second word back to back");

    // A dropped insert never reports a hit and always answers -1
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.table_full) |-> (!m_word.hit && m_word.answer == -32'sd1))
        else $error("table_full result with hit or valid answer");

    // A miss always answers -1
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_word.hit) |-> (m_word.answer == -32'sd1))
        else $error("miss result without -1 answer");

    // A result is loaded only while the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> st.out_free)
        else $error("result loaded over a pending word");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bidirectional_id_map_core. A behavioral map of
// index-to-label and first-index-per-label predicts every answer word; a
// checker compares each result word field by field, in order. Directed
// corner cases are followed by a random mix with hash collisions, a long
// receiver stall, a fill up to capacity and a run against the full table.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         TAIL_CYCLES = 200;
    localparam int         LIMIT_CYCLES = 20_000_000;
    localparam int         MAX_REPORTS = 10;

    // Low 11 bits that share hash slots; 11'h7FF lands on the slot of label -1
    localparam logic [10:0] HOT_LOW [4] = '{11'h000, 11'h001, 11'h7FF, 11'h400};

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    bim_pkg::in_word_t  s_word  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    bim_pkg::out_word_t m_word;

    bidirectional_id_map_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted map state
    // ------------------------------------------------------------------
    logic [31:0]        label_mem [bim_pkg::LABEL_DEPTH];
    int unsigned        fill;
    int unsigned        first_index [logic [31:0]];
    logic [31:0]        known_labels [$];
    bim_pkg::out_word_t pending_answers [$];

    bit idle_en  = 1'b1;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;

    int unsigned n_insert, n_drop, n_fwd, n_rev, n_unused;
    int unsigned n_checked, n_bad;
    int unsigned cycle_count;

    function automatic void map_reset();
        fill = 1;
        label_mem[0] = bim_pkg::MISS_WORD;
        first_index.delete();
        first_index[bim_pkg::MISS_WORD] = 0;
        known_labels.delete();
        known_labels = {known_labels, bim_pkg::MISS_WORD};
    endfunction

    // Apply one word to the predicted map and return the answer it gives
    function automatic bim_pkg::out_word_t map_apply(input bim_pkg::in_word_t w);
        bim_pkg::out_word_t r;
        logic [31:0]        key;
        r.answer     = bim_pkg::MISS_WORD;
        r.hit        = 1'b0;
        r.table_full = 1'b0;
        key          = w.label;
        case (w.opcode)
            bim_pkg::OP_INSERT: begin
                n_insert++;
                if (fill >= bim_pkg::LABEL_DEPTH) begin
                    r.table_full = 1'b1;
                    n_drop++;
                end else begin
                    label_mem[fill] = key;
                    if (!first_index.exists(key)) begin
                        first_index[key] = fill;
                        known_labels = {known_labels, key};
                    end
                    r.answer = 32'(fill);
                    r.hit    = 1'b1;
                    fill++;
                end
            end
            bim_pkg::OP_LABEL_OF_IDX: begin
                n_fwd++;
                if (w.vertex_index < fill) begin
                    r.answer = label_mem[w.vertex_index];
                    r.hit    = 1'b1;
                end
            end
            bim_pkg::OP_IDX_OF_LABEL: begin
                n_rev++;
                if (first_index.exists(key)) begin
                    r.answer = 32'(first_index[key]);
                    r.hit    = 1'b1;
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic bim_pkg::in_word_t mk(input logic [1:0] op, input logic [31:0] lab,
                                             input logic [9:0] vix);
        bim_pkg::in_word_t w;
        w.opcode       = op;
        w.label        = lab;
        w.vertex_index = vix;
        return w;
    endfunction

    // Mix of colliding, extreme, already stored and fully random labels
    function automatic logic [31:0] pick_label();
        logic [31:0] lab;
        lab = $urandom();
        case ($urandom_range(0, 9))
            0, 1: lab[10:0] = HOT_LOW[$urandom_range(0, 3)];
            2: begin
                case ($urandom_range(0, 3))
                    0: lab = 32'h0000_0000;
                    1: lab = 32'hFFFF_FFFF;
                    2: lab = 32'h7FFF_FFFF;
                    default: lab = 32'h8000_0000;
                endcase
            end
            3, 4, 5: lab = known_labels[$urandom_range(0, known_labels.size() - 1)];
            default: ;
        endcase
        return lab;
    endfunction

    function automatic bim_pkg::in_word_t random_word();
        bim_pkg::in_word_t w;
        int unsigned       pick;
        w.label        = $urandom();
        w.vertex_index = 10'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            w.opcode = bim_pkg::OP_INSERT;
            w.label  = pick_label();
        end else if (pick < 65) begin
            w.opcode = bim_pkg::OP_LABEL_OF_IDX;
            if ($urandom_range(0, 9) < 7)
                w.vertex_index = 10'($urandom_range(0, fill - 1));
        end else if (pick < 95) begin
            w.opcode = bim_pkg::OP_IDX_OF_LABEL;
            w.label  = pick_label();
        end else begin
            w.opcode = OP_UNUSED;
        end
        return w;
    endfunction

    // Offer one word, hold it until accepted, then record its answer.
    // Valid is left high on return; the caller either offers the next word
    // in the same step or lowers valid through a gap or a drain.
    task automatic send_word(input bim_pkg::in_word_t w);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge aclk);
        end
        s_word  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_answers = {pending_answers, map_apply(w)};
    endtask

    // Stop offering and wait for every outstanding answer
    task automatic wait_answers_done();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // preload, misses on an empty table
        send_word(mk(bim_pkg::OP_LABEL_OF_IDX, 32'h1234_5678, 10'd0));
        send_word(mk(bim_pkg::OP_IDX_OF_LABEL, 32'hFFFF_FFFF, 10'd0));
        send_word(mk(bim_pkg::OP_LABEL_OF_IDX, 32'h0, 10'd1));
        send_word(mk(bim_pkg::OP_LABEL_OF_IDX, 32'h0, 10'd1023));
        send_word(mk(bim_pkg::OP_IDX_OF_LABEL, 32'h7FFF_FFFF, 10'd0));
        // extreme labels and a duplicate of the preload
        send_word(mk(bim_pkg::OP_INSERT, 32'h7FFF_FFFF, 10'd0));
        send_word(mk(bim_pkg::OP_INSERT, 32'h8000_0000, 10'h3FF));
        send_word(mk(bim_pkg::OP_INSERT, 32'h0000_0000, 10'd0));
        send_word(mk(bim_pkg::OP_INSERT, 32'hFFFF_FFFF, 10'd0));
        send_word(mk(bim_pkg::OP_IDX_OF_LABEL, 32'hFFFF_FFFF, 10'h3FF));
        // duplicate keeps its first index for reverse lookup
        send_word(mk(bim_pkg::OP_INSERT, 32'h7FFF_FFFF, 10'd0));
        send_word(mk(bim_pkg::OP_IDX_OF_LABEL, 32'h7FFF_FFFF, 10'd0));
        send_word(mk(bim_pkg::OP_LABEL_OF_IDX, 32'h0, 10'd5));
        send_word(mk(bim_pkg::OP_LABEL_OF_IDX, 32'hFFFF_FFFF, 10'd4));
        send_word(mk(bim_pkg::OP_LABEL_OF_IDX, 32'h0, 10'd6));
        // unused opcode with all-ones fields
        send_word(mk(OP_UNUSED, 32'hFFFF_FFFF, 10'h3FF));
        // collision with label 0, then a probe past the chain
        send_word(mk(bim_pkg::OP_INSERT, 32'h0000_0800, 10'h3FF));
        send_word(mk(bim_pkg::OP_IDX_OF_LABEL, 32'h0000_0800, 10'd0));
        send_word(mk(bim_pkg::OP_IDX_OF_LABEL, 32'h0000_1000, 10'd0));
        send_word(mk(bim_pkg::OP_IDX_OF_LABEL, 32'h0000_0000, 10'h3FF));
        send_word(mk(bim_pkg::OP_IDX_OF_LABEL, 32'h8000_0000, 10'h3FF));
        wait_answers_done();
    endtask

    task automatic test_random_mix(input int unsigned count);
        repeat (count) send_word(random_word());
        wait_answers_done();
    endtask

    // Receiver stalls for a long stretch while words keep coming
    task automatic test_receiver_hold();
        hold_req = 1'b1;
        repeat (16) send_word(random_word());
        wait_answers_done();
        if (!hold_seen) begin
            n_bad++;
            $display("receiver hold-off never took place");
        end
    endtask

    task automatic test_fill_to_capacity();
        logic [31:0] lab;
        while (fill < bim_pkg::LABEL_DEPTH) begin
            lab = ($urandom_range(0, 9) < 8) ? $urandom() : pick_label();
            send_word(mk(bim_pkg::OP_INSERT, lab, 10'($urandom())));
            if ($urandom_range(0, 7) == 0)
                send_word(random_word());
        end
        wait_answers_done();
    endtask

    // Last part, without idling: drops and lookups on the full table
    task automatic test_full_table();
        idle_en = 1'b0;
        send_word(mk(bim_pkg::OP_INSERT, $urandom(), 10'($urandom())));
        send_word(mk(bim_pkg::OP_INSERT, 32'hFFFF_FFFF, 10'd0));
        send_word(mk(bim_pkg::OP_INSERT, 32'h8000_0000, 10'h3FF));
        send_word(mk(bim_pkg::OP_LABEL_OF_IDX, $urandom(), 10'd1023));
        send_word(mk(bim_pkg::OP_LABEL_OF_IDX, $urandom(), 10'd0));
        send_word(mk(bim_pkg::OP_IDX_OF_LABEL, label_mem[bim_pkg::LABEL_DEPTH - 1],
                     10'($urandom())));
        send_word(mk(bim_pkg::OP_IDX_OF_LABEL, 32'hFFFF_FFFF, 10'($urandom())));
        send_word(mk(OP_UNUSED, $urandom(), 10'($urandom())));
        repeat (10) send_word(random_word());
        wait_answers_done();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long requested hold-off
    // ------------------------------------------------------------------
    initial begin : receiver
        int unsigned hold_left;
        int unsigned stall;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready   <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(posedge aclk);
                    hold_left--;
                end
                hold_req  = 1'b0;
                hold_seen = 1'b1;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                stall = $urandom_range(1, 5);
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each accepted result word with the oldest answer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bim_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("unexpected result word: answer=%h hit=%b full=%b",
                             m_word.answer, m_word.hit, m_word.table_full);
            end else begin
                want = pending_answers.pop_front();
                n_checked++;
                if (m_word.answer !== want.answer || m_word.hit !== want.hit ||
                    m_word.table_full !== want.table_full) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS) begin
                        $display("mismatch word %0d: expected answer=%h hit=%b full=%b,",
                                 n_checked, want.answer, want.hit, want.table_full);
                        $display("    got answer=%h hit=%b full=%b",
                                 m_word.answer, m_word.hit, m_word.table_full);
                    end
                end
            end
        end
    end

    // Abort on a hung handshake
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, pending_answers.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        map_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_mix(100);
        test_receiver_hold();
        test_fill_to_capacity();
        test_full_table();

        // settle, then make sure nothing stray comes out
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_answers.size() != 0) begin
            n_bad++;
            $display("%0d answers never arrived", pending_answers.size());
        end

        $display("checked %0d words: %0d inserts (%0d dropped on a full table), %0d forward,",
                 n_checked, n_insert, n_drop, n_fwd);
        $display("%0d reverse lookups, %0d unused opcodes; %0d labels distinct; %0d failures",
                 n_rev, n_unused, known_labels.size(), n_bad);
        if (n_bad == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== bidirectional_id_map_core.f =====
sv/bim_pkg.sv
sv/bim_ram.sv
sv/bim_ctrl.sv
sv/bim_dpath.sv
sv/bidirectional_id_map_core.sv
dv/tb.sv
